// ----- hdl/cfd_pkg.sv -----
package cfd_pkg;

    localparam logic [7:0]  CODE_FULL    = 8'hFF;
    localparam logic [15:0] CAP_RESET    = 16'hFFFF;
    localparam logic [16:0] COUNT_SAT    = 17'h10000;
    localparam logic [15:0] LEN_SAT      = 16'hFFFF;
    localparam int          QUEUE_DEPTH  = 2;

    localparam logic [1:0]  STATUS_OK        = 2'd0;
    localparam logic [1:0]  STATUS_BAD_ENC   = 2'd1;
    localparam logic [1:0]  STATUS_TOO_SMALL = 2'd2;

    typedef struct packed {
        logic [7:0] enc_byte;
        logic       frame_last;
    } t_cfd_in;

    typedef struct packed {
        logic [7:0]  dec_byte;
        logic        dec_valid;
        logic        frame_done;
        logic [1:0]  frame_status;
        logic [15:0] frame_length;
    } t_cfd_out;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data;
        logic       emit;
        logic       bad;
        logic       last;
    } t_cfd_cmd;

endpackage

// ----- hdl/cfd_front.sv -----
module cfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  cfd_pkg::t_cfd_in i_item,
    output cfd_pkg::t_cfd_cmd o_cmd
);

    logic [7:0] r_block_left, n_block_left;
    logic       r_zero_pending, n_zero_pending;

    always_comb begin
        logic [7:0] b;
        b              = i_item.enc_byte;
        n_block_left   = r_block_left;
        n_zero_pending = r_zero_pending;
        o_cmd          = '0;
        o_cmd.last     = i_item.frame_last;
        if (r_block_left == 8'd0) begin
            if (b == 8'd0) begin
                o_cmd.bad      = 1'b1;
                n_zero_pending = 1'b0;
            end else begin
                // The zero that the previous block implied goes out before this code.
                o_cmd.emit     = r_zero_pending;
                n_block_left   = b - 8'd1;
                n_zero_pending = (b != cfd_pkg::CODE_FULL);
            end
        end else begin
            if (b == 8'd0) begin
                o_cmd.bad = 1'b1;
            end else begin
                o_cmd.emit = 1'b1;
                o_cmd.data = b;
            end
            n_block_left = r_block_left - 8'd1;
        end
        if (i_item.frame_last) begin
            if (n_block_left != 8'd0) begin
                o_cmd.bad = 1'b1;
            end
            n_block_left   = 8'd0;
            n_zero_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_left   <= 8'd0;
            r_zero_pending <= 1'b0;
        end else if (i_take) begin
            r_block_left   <= n_block_left;
            r_zero_pending <= n_zero_pending;
        end
    end

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_item.frame_last) |=> (r_block_left == 8'd0 && !r_zero_pending))
        else $error("front state not cleared after frame end");

    a_zero_not_emitted_as_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && r_block_left != 8'd0) |-> (o_cmd.data != 8'd0))
        else $error("zero data byte passed through");

endmodule

// ----- hdl/cfd_queue.sv -----
module cfd_queue #(
    parameter int DEPTH = cfd_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  cfd_pkg::t_cfd_cmd i_wr_data,
    input  logic              i_rd,
    output cfd_pkg::t_cfd_cmd o_rd_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cfd_pkg::t_cfd_cmd r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              wr_ok, rd_ok;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign wr_ok     = i_wr && !o_full;
    assign rd_ok     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr_ok && !rd_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_ok && !wr_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count above depth");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_rd) |=> o_full)
        else $error("full queue lost an entry without a read");

endmodule

// ----- hdl/cfd_back.sv -----
module cfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_capacity,
    input  logic              i_cmd_valid,
    input  cfd_pkg::t_cfd_cmd i_cmd,
    output logic              o_cmd_take,
    input  logic              i_pop,
    output logic              o_empty,
    output cfd_pkg::t_cfd_out o_item
);

    logic              r_valid;
    cfd_pkg::t_cfd_out r_out, n_out;
    logic [16:0]       r_count, n_count;
    logic              r_bad, n_bad;

    assign o_cmd_take = i_cmd_valid && (!r_valid || i_pop);
    assign o_empty    = !r_valid;
    assign o_item     = r_out;

    always_comb begin
        n_count = r_count;
        if (i_cmd.emit && r_count != cfd_pkg::COUNT_SAT) begin
            n_count = r_count + 17'd1;
        end
        n_bad            = r_bad || i_cmd.bad;
        n_out            = '0;
        n_out.dec_valid  = i_cmd.emit;
        n_out.dec_byte   = i_cmd.emit ? i_cmd.data : 8'd0;
        n_out.frame_done = i_cmd.last;
        if (i_cmd.last) begin
            if (n_bad) begin
                n_out.frame_status = cfd_pkg::STATUS_BAD_ENC;
            end else if (n_count > {1'b0, i_capacity}) begin
                n_out.frame_status = cfd_pkg::STATUS_TOO_SMALL;
            end else begin
                n_out.frame_status = cfd_pkg::STATUS_OK;
            end
            n_out.frame_length = n_count[16] ? cfd_pkg::LEN_SAT : n_count[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= 17'd0;
            r_bad   <= 1'b0;
        end else begin
            if (o_cmd_take) begin
                r_valid <= 1'b1;
                r_count <= i_cmd.last ? 17'd0 : n_count;
                r_bad   <= i_cmd.last ? 1'b0 : n_bad;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    a_status_only_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_out.frame_done) |->
            (r_out.frame_status == cfd_pkg::STATUS_OK && r_out.frame_length == 16'd0))
        else $error("status or length shown outside frame end");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cfd_pkg::COUNT_SAT)
        else $error("decoded count beyond saturation");

endmodule

// ----- hdl/cobs_frame_decoder.sv -----
// COBS frame decoder, one encoded byte per item.
// Input channel: drive i_item (enc_byte, frame_last) and raise push; the item
// is taken at a clock edge where push is high and full is low. Mark the last
// encoded byte of each frame with frame_last.
// Result channel: while empty is low, o_item holds the oldest result; raise
// pop to take it. Every input item yields exactly one result: a decoded byte
// when dec_valid is set, and on the frame's last item frame_done with the
// frame status (ok, invalid encoding, buffer too small) and decoded length.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the decoded capacity
// register (reset 65535); write it only while no frame is in flight.
// With the result side free, an accepted item passes through the command queue
// and then the output register before its result reaches o_item.
// Throughput is one item per cycle unless full, set by the per-byte classify
// step in the front part and the single count update in the back part.
// When the receiver stalls, the output register and the command queue
// (QUEUE_DEPTH entries) fill, then full rises until pop resumes.
// A synchronous reset clears the decoder state and both channels; the
// capacity register returns to 65535.
module cobs_frame_decoder #(
    parameter int QUEUE_DEPTH = cfd_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  cfd_pkg::t_cfd_in  i_item,
    output logic              empty,
    input  logic              pop,
    output cfd_pkg::t_cfd_out o_item,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data
);

    logic [15:0]       r_capacity;
    logic              take;
    cfd_pkg::t_cfd_cmd front_cmd;
    cfd_pkg::t_cfd_cmd queue_cmd;
    logic              queue_empty;
    logic              back_take;

    assign take = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= cfd_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    cfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_item),
        .o_cmd   (front_cmd)
    );

    cfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (take),
        .i_wr_data (front_cmd),
        .i_rd      (back_take),
        .o_rd_data (queue_cmd),
        .o_full    (full),
        .o_empty   (queue_empty)
    );

    cfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_cmd_valid (!queue_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_take  (back_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_item)
    );

endmodule
